// File: src/omau_pkg.sv
// Shared types, sizes and codes for the object map associate/update unit.
// Used by omau_ctrl, omau_dp and object_map_associate_update_unit.
`default_nettype none
package omau_pkg;

  localparam int TABLE_DEPTH    = 64;
  localparam int IDX_W          = $clog2(TABLE_DEPTH);
  localparam int CNT_W          = IDX_W + 1;
  localparam int ID_W           = 32;
  localparam int POS_W          = 20;
  localparam int REG_W          = 32;
  localparam int KEYPOINT_COUNT = 17;
  localparam int MASK_W         = 17;
  localparam int PARTS_W        = 4;
  localparam int INDEX_W        = 6;
  localparam int OUTCOME_W      = 2;
  localparam int CFG_IDX_W      = 2;

  // Keypoint groups: head, arm, body, and everything above is leg.
  localparam int HEAD_LAST = 4;
  localparam int ARM_LAST  = 10;
  localparam int BODY_LAST = 12;

  // Distance arithmetic.
  localparam int DIFF_W = POS_W + 1;   // signed difference of two positions
  localparam int SQ_W   = 2 * POS_W;   // square of a magnitude below 2^POS_W
  localparam int DIST_W = SQ_W + 1;    // sum of two squares

  // Smoothing: (4*old + obs) / 5 by reciprocal multiplication.
  localparam int SUM_W       = POS_W + 3;
  localparam int NUM_W       = SUM_W - 1;
  localparam int RECIP_SHIFT = 25;
  localparam int RECIP_W     = 23;
  localparam int PROD_W      = NUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP5 = RECIP_W'((2 ** RECIP_SHIFT + 4) / 5);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_DIST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_MIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_MAX   = 2'd2;

  localparam logic [REG_W-1:0] MATCH_DIST_RESET = 32'd1000000;
  localparam logic [REG_W-1:0] GATE_MIN_RESET   = 32'd40000;
  localparam logic [REG_W-1:0] GATE_MAX_RESET   = 32'd250000;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_UPDATED  = 2'd0,
    OUT_GATED    = 2'd1,
    OUT_INSERTED = 2'd2,
    OUT_FULL     = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    KIND_MATCH,
    KIND_INSERT,
    KIND_FULL
  } kind_t;

  typedef struct packed {
    logic [ID_W-1:0]    track;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [PARTS_W-1:0] parts;
  } entry_t;

  typedef struct packed {
    logic             in_ready;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_last;
    logic             commit;
    kind_t            kind;
    logic [IDX_W-1:0] ins_addr;
  } omau_cmd_t;

  typedef struct packed {
    logic found;
    logic missed;
    logic out_busy;
  } omau_status_t;

  function automatic logic [PARTS_W-1:0] parts_from_mask(input logic [MASK_W-1:0] mask);
    logic [PARTS_W-1:0] p;
    p = '0;
    for (int i = 0; i < KEYPOINT_COUNT && i < MASK_W; i++) begin
      if (mask[i]) begin
        if (i <= HEAD_LAST) begin
          p[0] = 1'b1;
        end else if (i <= ARM_LAST) begin
          p[1] = 1'b1;
        end else if (i <= BODY_LAST) begin
          p[2] = 1'b1;
        end else begin
          p[3] = 1'b1;
        end
      end
    end
    return p;
  endfunction

endpackage
`default_nettype wire

// File: src/omau_ctrl.sv
// Controller of the object map unit: input handshake, table scan sequencing,
// entry count and commit timing. Depends on omau_pkg.
`default_nettype none
module omau_ctrl import omau_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  omau_status_t status,
  output omau_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_COMMIT,
    ST_DONE
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] scan_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      scan_next    <= '0;
      cmd.in_ready <= 1'b1;
      cmd.rd_en    <= 1'b0;
      cmd.rd_addr  <= '0;
      cmd.rd_last  <= 1'b0;
      cmd.commit   <= 1'b0;
      cmd.kind     <= KIND_FULL;
      cmd.ins_addr <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cmd.in_ready <= 1'b0;
            if (count != '0) begin
              cmd.rd_en   <= 1'b1;
              cmd.rd_addr <= '0;
              cmd.rd_last <= (count == CNT_W'(1));
              scan_next   <= CNT_W'(1);
              state       <= ST_SCAN;
            end else begin
              cmd.kind <= KIND_INSERT;
              state    <= ST_WAIT;
            end
          end
        end
        ST_SCAN: begin
          if (status.found) begin
            cmd.rd_en <= 1'b0;
            cmd.kind  <= KIND_MATCH;
            state     <= ST_WAIT;
          end else if (status.missed) begin
            cmd.rd_en <= 1'b0;
            cmd.kind  <= (count == CNT_W'(TABLE_DEPTH)) ? KIND_FULL : KIND_INSERT;
            state     <= ST_WAIT;
          end else if (scan_next < count) begin
            cmd.rd_en   <= 1'b1;
            cmd.rd_addr <= scan_next[IDX_W-1:0];
            cmd.rd_last <= (scan_next == count - CNT_W'(1));
            scan_next   <= scan_next + CNT_W'(1);
          end else begin
            cmd.rd_en <= 1'b0;
          end
        end
        // Gives the smoothing pipeline time to settle after a hit.
        ST_WAIT: begin
          state <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (!status.out_busy) begin
            cmd.commit   <= 1'b1;
            cmd.ins_addr <= count[IDX_W-1:0];
            if (cmd.kind == KIND_INSERT) begin
              count <= count + CNT_W'(1);
            end
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          cmd.commit   <= 1'b0;
          cmd.in_ready <= 1'b1;
          state        <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && cmd.kind == KIND_FULL) |-> (count == CNT_W'(TABLE_DEPTH)))
    else $error("drop committed with free table slots");

  a_one_word_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && cmd.in_ready) |=> !cmd.in_ready)
    else $error("ready held after accepting a word");

endmodule
`default_nettype wire

// File: src/omau_dp.sv
// Datapath of the object map unit: config registers, entry table memory,
// distance pipeline, smoothing and result register. Depends on omau_pkg.
`default_nettype none
module omau_dp import omau_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  omau_cmd_t                   cmd,
  output omau_status_t                status,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [REG_W-1:0]            cfg_data,
  input  logic                        in_valid,
  input  logic [ID_W-1:0]             obs_track_id,
  input  logic signed [POS_W-1:0]     pos_x,
  input  logic signed [POS_W-1:0]     pos_y,
  input  logic signed [POS_W-1:0]     pos_z,
  input  logic [MASK_W-1:0]           keypoint_mask,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [OUTCOME_W-1:0]        outcome,
  output logic [INDEX_W-1:0]          entry_index,
  output logic signed [POS_W-1:0]     entry_x,
  output logic signed [POS_W-1:0]     entry_y,
  output logic [PARTS_W-1:0]          entry_parts
);

  // Magnitude of a - b, which always fits POS_W bits.
  function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b);
    logic signed [DIFF_W-1:0] d;
    d = $signed({a[POS_W-1], a}) - $signed({b[POS_W-1], b});
    return d[DIFF_W-1] ? POS_W'(-d) : POS_W'(d);
  endfunction

  // Sign and rounded numerator |4*old + obs| + 2.
  function automatic logic [NUM_W:0] smooth_num(input logic [POS_W-1:0] old,
                                                input logic [POS_W-1:0] obs);
    logic signed [SUM_W-1:0] s;
    logic        [SUM_W-1:0] mag;
    s   = ($signed({{3{old[POS_W-1]}}, old}) <<< 2) + $signed({{3{obs[POS_W-1]}}, obs});
    mag = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
    return {s[SUM_W-1], mag[NUM_W-1:0] + NUM_W'(2)};
  endfunction

  logic [REG_W-1:0] match_dist_sq;
  logic [REG_W-1:0] gate_min_sq;
  logic [REG_W-1:0] gate_max_sq;

  logic               accept;
  logic [ID_W-1:0]    id_r;
  logic [POS_W-1:0]   px_r;
  logic [POS_W-1:0]   py_r;
  logic [POS_W-1:0]   pz_r;
  logic [MASK_W-1:0]  mask_r;

  logic [POS_W-1:0]   apz;
  logic [SQ_W-1:0]    pz2;
  logic               thr_ok;
  logic [REG_W-1:0]   thr;

  entry_t             mem [TABLE_DEPTH];
  entry_t             rd_q;
  logic               we;
  logic [IDX_W-1:0]   wa;
  entry_t             wd;

  logic               p0_v;
  logic               p0_last;
  logic [IDX_W-1:0]   p0_idx;
  logic               p1_v;
  logic               p1_last;
  logic [IDX_W-1:0]   p1_idx;
  entry_t             p1_e;
  logic [POS_W-1:0]   p1_adx;
  logic [POS_W-1:0]   p1_ady;
  logic               p1_ideq;
  logic               p2_v;
  logic               p2_last;
  logic [IDX_W-1:0]   p2_idx;
  entry_t             p2_e;
  logic [SQ_W-1:0]    p2_sqx;
  logic [SQ_W-1:0]    p2_sqy;
  logic               p2_ideq;
  logic [DIST_W-1:0]  d2;
  logic               hit;

  logic               found;
  logic               missed;
  entry_t             h_e;
  logic [IDX_W-1:0]   h_idx;
  logic [DIST_W-1:0]  h_d2;
  logic               gated;

  logic [NUM_W:0]     num_x;
  logic [NUM_W:0]     num_y;
  logic               neg_x;
  logic               neg_y;
  logic [NUM_W-1:0]   n_x;
  logic [NUM_W-1:0]   n_y;
  logic               pneg_x;
  logic               pneg_y;
  logic [PROD_W-1:0]  prod_x;
  logic [PROD_W-1:0]  prod_y;
  logic [POS_W-1:0]   q_x;
  logic [POS_W-1:0]   q_y;
  logic [POS_W-1:0]   sx;
  logic [POS_W-1:0]   sy;
  logic [PARTS_W-1:0] new_parts;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && cmd.in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_dist_sq <= MATCH_DIST_RESET;
      gate_min_sq   <= GATE_MIN_RESET;
      gate_max_sq   <= GATE_MAX_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MATCH_DIST: match_dist_sq <= cfg_data;
        REG_GATE_MIN:   gate_min_sq   <= cfg_data;
        REG_GATE_MAX:   gate_max_sq   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      id_r   <= obs_track_id;
      px_r   <= pos_x;
      py_r   <= pos_y;
      pz_r   <= pos_z;
      mask_r <= keypoint_mask;
    end
  end

  // The z term is fixed for one word, so the match threshold is reduced
  // by z^2 once and each entry only needs the planar distance.
  assign apz = pz_r[POS_W-1] ? POS_W'(-pz_r) : pz_r;

  always_ff @(posedge clk) begin
    pz2    <= SQ_W'(apz) * SQ_W'(apz);
    thr_ok <= pz2 < SQ_W'(match_dist_sq);
    thr    <= match_dist_sq - pz2[REG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_q <= mem[cmd.rd_addr];
    end
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // Scan pipeline: read, differences, squares, then compare.
  always_ff @(posedge clk) begin
    if (rst || accept) begin
      p0_v <= 1'b0;
      p1_v <= 1'b0;
      p2_v <= 1'b0;
    end else begin
      p0_v <= cmd.rd_en;
      p1_v <= p0_v;
      p2_v <= p1_v;
    end
  end

  always_ff @(posedge clk) begin
    p0_last <= cmd.rd_last;
    p0_idx  <= cmd.rd_addr;
    p1_last <= p0_last;
    p1_idx  <= p0_idx;
    p1_e    <= rd_q;
    p1_adx  <= abs_diff(px_r, rd_q.x);
    p1_ady  <= abs_diff(py_r, rd_q.y);
    p1_ideq <= (rd_q.track == id_r);
    p2_last <= p1_last;
    p2_idx  <= p1_idx;
    p2_e    <= p1_e;
    p2_sqx  <= SQ_W'(p1_adx) * SQ_W'(p1_adx);
    p2_sqy  <= SQ_W'(p1_ady) * SQ_W'(p1_ady);
    p2_ideq <= p1_ideq;
  end

  assign d2  = DIST_W'(p2_sqx) + DIST_W'(p2_sqy);
  assign hit = p2_ideq || (thr_ok && (d2 < DIST_W'(thr)));

  // Only the first hit in table order is kept; later words in flight drain.
  always_ff @(posedge clk) begin
    if (rst || accept) begin
      found  <= 1'b0;
      missed <= 1'b0;
    end else if (p2_v && !found && !missed) begin
      if (hit) begin
        found <= 1'b1;
      end else if (p2_last) begin
        missed <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p2_v && hit && !found && !missed) begin
      h_e   <= p2_e;
      h_idx <= p2_idx;
      h_d2  <= d2;
    end
  end

  // Smoothing of the held entry, three register stages.
  assign num_x = smooth_num(h_e.x, px_r);
  assign num_y = smooth_num(h_e.y, py_r);
  assign q_x   = prod_x[PROD_W-1:RECIP_SHIFT];
  assign q_y   = prod_y[PROD_W-1:RECIP_SHIFT];

  always_ff @(posedge clk) begin
    gated  <= (h_d2 < DIST_W'(gate_min_sq)) || (h_d2 > DIST_W'(gate_max_sq));
    neg_x  <= num_x[NUM_W];
    neg_y  <= num_y[NUM_W];
    n_x    <= num_x[NUM_W-1:0];
    n_y    <= num_y[NUM_W-1:0];
    pneg_x <= neg_x;
    pneg_y <= neg_y;
    prod_x <= PROD_W'(n_x) * PROD_W'(RECIP5);
    prod_y <= PROD_W'(n_y) * PROD_W'(RECIP5);
    sx     <= pneg_x ? POS_W'(-q_x) : q_x;
    sy     <= pneg_y ? POS_W'(-q_y) : q_y;
  end

  assign new_parts = parts_from_mask(mask_r);

  always_comb begin
    we = 1'b0;
    wa = h_idx;
    wd = h_e;
    case (cmd.kind)
      KIND_MATCH: begin
        we   = cmd.commit && !gated;
        wd.x = sx;
        wd.y = sy;
      end
      KIND_INSERT: begin
        we       = cmd.commit;
        wa       = cmd.ins_addr;
        wd.track = id_r;
        wd.x     = px_r;
        wd.y     = py_r;
        wd.parts = new_parts;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      case (cmd.kind)
        KIND_MATCH: begin
          outcome     <= gated ? OUT_GATED : OUT_UPDATED;
          entry_index <= INDEX_W'(h_idx);
          entry_x     <= gated ? h_e.x : sx;
          entry_y     <= gated ? h_e.y : sy;
          entry_parts <= h_e.parts;
        end
        KIND_INSERT: begin
          outcome     <= OUT_INSERTED;
          entry_index <= INDEX_W'(cmd.ins_addr);
          entry_x     <= px_r;
          entry_y     <= py_r;
          entry_parts <= new_parts;
        end
        default: begin
          outcome     <= OUT_FULL;
          entry_index <= '0;
          entry_x     <= '0;
          entry_y     <= '0;
          entry_parts <= '0;
        end
      endcase
    end
  end

  assign status.found    = found;
  assign status.missed   = missed;
  assign status.out_busy = out_valid && !out_ready;

  a_single_verdict: assert property (@(posedge clk) disable iff (rst)
    !(found && missed))
    else $error("scan reported both a hit and a miss");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result loaded over a word not yet taken");

endmodule
`default_nettype wire

// File: src/object_map_associate_update_unit.sv
// Top level of the object map associate/update unit: joins controller and
// datapath. Depends on omau_pkg, omau_ctrl and omau_dp.
//
//   channel  handshake             payload
//   cfg      cfg_valid/cfg_ready   cfg_index, cfg_data
//   in       in_valid/in_ready     obs_track_id, pos_x, pos_y, pos_z, keypoint_mask
//   out      out_valid/out_ready   outcome, entry_index, entry_x, entry_y, entry_parts
//
// One word at a time: the scan reads one table entry per cycle through a
// four-stage distance pipeline, and stops at the first match or after the
// last entry. With an empty table there is no scan and the word goes straight
// to an insert. The next word is accepted only after the result is loaded.
// Reset empties the table at once; no clearing pass is needed.
// A result waiting on out_ready holds the unit before its commit.
`default_nettype none
module object_map_associate_update_unit import omau_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [REG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [ID_W-1:0]         obs_track_id,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic [MASK_W-1:0]       keypoint_mask,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [OUTCOME_W-1:0]    outcome,
  output logic [INDEX_W-1:0]      entry_index,
  output logic signed [POS_W-1:0] entry_x,
  output logic signed [POS_W-1:0] entry_y,
  output logic [PARTS_W-1:0]      entry_parts
);

  omau_cmd_t    cmd;
  omau_status_t status;

  assign in_ready = cmd.in_ready;

  omau_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd)
  );

  omau_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .obs_track_id  (obs_track_id),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .keypoint_mask (keypoint_mask),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .outcome       (outcome),
    .entry_index   (entry_index),
    .entry_x       (entry_x),
    .entry_y       (entry_y),
    .entry_parts   (entry_parts)
  );

endmodule
`default_nettype wire
